>>> rtl/fpfa_pkg.sv
// Package for the fixed partition fit allocator: item structs, policy and
// opcode codes, register indexes and the scan control struct of the cell row.
// No dependencies.
package fpfa_pkg;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 5;
   localparam int POLICY_BITS    = 2;
   localparam int COUNT_BITS     = 5;
   localparam int INDEX_BITS     = 4;
   localparam int FIELD_SIZE_BITS = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIT_POLICY       = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PARTITIONS_IN_USE = 1'd1;

   localparam logic [COUNT_BITS-1:0] COUNT_RESET = 5'd16;

   typedef enum logic [POLICY_BITS-1:0] {
      FIT_FIRST = 2'd0,
      FIT_BEST  = 2'd1,
      FIT_NEXT  = 2'd2,
      FIT_WORST = 2'd3
   } fit_policy_type;

   typedef enum logic [0:0] {
      OP_LOAD    = 1'b0,
      OP_REQUEST = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESULT
   } ctrl_state_type;

   typedef struct packed {
      opcode_type                 opcode;
      logic [INDEX_BITS-1:0]      part_index;
      logic [FIELD_SIZE_BITS-1:0] size_value;
   } req_type;

   typedef struct packed {
      logic                       granted;
      logic [INDEX_BITS-1:0]      granted_index;
      logic [FIELD_SIZE_BITS-1:0] leftover_size;
   } rsp_type;

   // Control part of the search token that moves down the cell row.
   typedef struct packed {
      logic valid;
      logic cand_found;
      logic wrap_found;
   } scan_ctl_type;

endpackage

>>> rtl/fpfa_cell.sv
// One partition cell: holds a partition's size and used mark and updates the
// search token passing through it. Depends on fpfa_pkg.
module fpfa_cell #(
   parameter int CELL_ID = 0,
   parameter int IDX_W   = 4,
   parameter int CNT_W   = 5,
   parameter int SIZE_W  = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [IDX_W-1:0]       wr_idx,
   input  logic [SIZE_W-1:0]      wr_size,
   input  logic                   wr_used,
   input  fpfa_pkg::fit_policy_type policy,
   input  logic [SIZE_W-1:0]      want,
   input  logic [IDX_W-1:0]       start,
   input  logic [CNT_W-1:0]       active,
   input  fpfa_pkg::scan_ctl_type ctl_in,
   input  logic [IDX_W-1:0]       cand_idx_in,
   input  logic [SIZE_W-1:0]      cand_size_in,
   input  logic [IDX_W-1:0]       wrap_idx_in,
   input  logic [SIZE_W-1:0]      wrap_size_in,
   output fpfa_pkg::scan_ctl_type ctl_out,
   output logic [IDX_W-1:0]       cand_idx_out,
   output logic [SIZE_W-1:0]      cand_size_out,
   output logic [IDX_W-1:0]       wrap_idx_out,
   output logic [SIZE_W-1:0]      wrap_size_out
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_ID);
   localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_ID);

   logic [SIZE_W-1:0]      size_ff;
   logic                   used_ff;
   fpfa_pkg::scan_ctl_type ctl_ff, ctl_in_next;
   logic [IDX_W-1:0]       cand_idx_ff, wrap_idx_ff;
   logic [SIZE_W-1:0]      cand_size_ff, wrap_size_ff;

   logic hit, better, take, take_wrap;

   always_comb begin
      // Cells beyond the active count never match, whatever they hold.
      hit = (MY_CNT < active) && !used_ff && (size_ff >= want);
      better = !ctl_in.cand_found
               || ((policy == fpfa_pkg::FIT_BEST)  && (size_ff < cand_size_in))
               || ((policy == fpfa_pkg::FIT_WORST) && (size_ff > cand_size_in));
      take = hit && better && ((policy != fpfa_pkg::FIT_NEXT) || (MY_IDX >= start));
      take_wrap = hit && !ctl_in.wrap_found;
      ctl_in_next.valid      = ctl_in.valid;
      ctl_in_next.cand_found = ctl_in.cand_found || take;
      ctl_in_next.wrap_found = ctl_in.wrap_found || take_wrap;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
         ctl_ff  <= '0;
      end else begin
         if (wr_en && (wr_idx == MY_IDX)) begin
            used_ff <= wr_used;
         end
         ctl_ff <= ctl_in_next;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && (wr_idx == MY_IDX)) begin
         size_ff <= wr_size;
      end
      cand_idx_ff  <= take ? MY_IDX : cand_idx_in;
      cand_size_ff <= take ? size_ff : cand_size_in;
      wrap_idx_ff  <= take_wrap ? MY_IDX : wrap_idx_in;
      wrap_size_ff <= take_wrap ? size_ff : wrap_size_in;
   end

   assign ctl_out       = ctl_ff;
   assign cand_idx_out  = cand_idx_ff;
   assign cand_size_out = cand_size_ff;
   assign wrap_idx_out  = wrap_idx_ff;
   assign wrap_size_out = wrap_size_ff;

endmodule

>>> rtl/fpfa_chain.sv
// Row of partition cells; the search token enters at cell 0, is registered in
// each cell in turn and leaves after the last cell. Depends on fpfa_pkg and fpfa_cell.
module fpfa_chain #(
   parameter int NUM_CELLS = 16,
   parameter int IDX_W     = 4,
   parameter int CNT_W     = 5,
   parameter int SIZE_W    = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [IDX_W-1:0]       wr_idx,
   input  logic [SIZE_W-1:0]      wr_size,
   input  logic                   wr_used,
   input  fpfa_pkg::fit_policy_type policy,
   input  logic [SIZE_W-1:0]      want,
   input  logic [IDX_W-1:0]       start,
   input  logic [CNT_W-1:0]       active,
   input  logic                   launch,
   output fpfa_pkg::scan_ctl_type tail_ctl,
   output logic [IDX_W-1:0]       tail_cand_idx,
   output logic [SIZE_W-1:0]      tail_cand_size,
   output logic [IDX_W-1:0]       tail_wrap_idx,
   output logic [SIZE_W-1:0]      tail_wrap_size
);

   fpfa_pkg::scan_ctl_type ctl_link [0:NUM_CELLS];
   logic [IDX_W-1:0]       cand_idx_link [0:NUM_CELLS];
   logic [SIZE_W-1:0]      cand_size_link [0:NUM_CELLS];
   logic [IDX_W-1:0]       wrap_idx_link [0:NUM_CELLS];
   logic [SIZE_W-1:0]      wrap_size_link [0:NUM_CELLS];

   assign ctl_link[0]       = {launch, 1'b0, 1'b0};
   assign cand_idx_link[0]  = '0;
   assign cand_size_link[0] = '0;
   assign wrap_idx_link[0]  = '0;
   assign wrap_size_link[0] = '0;

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      fpfa_cell #(
         .CELL_ID (i),
         .IDX_W   (IDX_W),
         .CNT_W   (CNT_W),
         .SIZE_W  (SIZE_W)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .wr_en         (wr_en),
         .wr_idx        (wr_idx),
         .wr_size       (wr_size),
         .wr_used       (wr_used),
         .policy        (policy),
         .want          (want),
         .start         (start),
         .active        (active),
         .ctl_in        (ctl_link[i]),
         .cand_idx_in   (cand_idx_link[i]),
         .cand_size_in  (cand_size_link[i]),
         .wrap_idx_in   (wrap_idx_link[i]),
         .wrap_size_in  (wrap_size_link[i]),
         .ctl_out       (ctl_link[i+1]),
         .cand_idx_out  (cand_idx_link[i+1]),
         .cand_size_out (cand_size_link[i+1]),
         .wrap_idx_out  (wrap_idx_link[i+1]),
         .wrap_size_out (wrap_size_link[i+1])
      );
   end

   assign tail_ctl       = ctl_link[NUM_CELLS];
   assign tail_cand_idx  = cand_idx_link[NUM_CELLS];
   assign tail_cand_size = cand_size_link[NUM_CELLS];
   assign tail_wrap_idx  = wrap_idx_link[NUM_CELLS];
   assign tail_wrap_size = wrap_size_link[NUM_CELLS];

endmodule

>>> rtl/fixed_partition_fit_allocator_unit.sv
// Fixed partition fit allocator top level: controller, registers and the row
// of partition cells. Depends on fpfa_pkg and fpfa_chain.
// A request item launches the search token down the cell row and is answered
// once the token leaves the last cell; a load item writes its cell when its
// index is in the table. The next item is taken only after the result of the
// last one has gone into the output register.
// Synchronous active-high reset clears the used marks, the next-fit pointer,
// the registers and the handshake state; partition sizes are not cleared.
module fixed_partition_fit_allocator_unit #(
   parameter int NUM_PARTITIONS = 16,
   parameter int SIZE_BITS      = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [fpfa_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [fpfa_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  fpfa_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output fpfa_pkg::rsp_type                   rsp_payload
);

   localparam int IDX_W  = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
   localparam int CNT_W  = $clog2(NUM_PARTITIONS + 1);
   localparam int CMP_W  = (CNT_W > fpfa_pkg::COUNT_BITS) ? CNT_W : fpfa_pkg::COUNT_BITS;
   localparam int IDX_XW = IDX_W + fpfa_pkg::INDEX_BITS;
   localparam int SZ_XW  = SIZE_BITS + fpfa_pkg::FIELD_SIZE_BITS;

   fpfa_pkg::ctrl_state_type state_ff, state_in;
   fpfa_pkg::fit_policy_type policy_ff;
   logic [fpfa_pkg::COUNT_BITS-1:0] count_ff;
   logic [IDX_W-1:0]     pointer_ff, pointer_in;
   logic [SIZE_BITS-1:0] want_ff, want_in;
   logic                 launch_ff, launch_in;
   fpfa_pkg::rsp_type    res_ff, res_in;
   fpfa_pkg::rsp_type    rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 wr_en, wr_used;
   logic [IDX_W-1:0]     wr_idx;
   logic [SIZE_BITS-1:0] wr_size;

   logic [CMP_W-1:0]     count_ext, active_cmp;
   logic [CNT_W-1:0]     active;
   logic [IDX_W-1:0]     start;

   logic [SZ_XW-1:0]     req_size_wide, pick_left_wide, load_left_wide;
   logic [SIZE_BITS-1:0] req_want, pick_size, pick_left;
   logic [IDX_W-1:0]     req_idx, pick_idx;
   logic [IDX_XW-1:0]    pick_idx_wide;
   logic                 req_accept, load_in_table, grant;

   fpfa_pkg::scan_ctl_type tail_ctl;
   logic [IDX_W-1:0]       tail_cand_idx, tail_wrap_idx;
   logic [SIZE_BITS-1:0]   tail_cand_size, tail_wrap_size;

   // Active count is the register clipped to the table depth.
   always_comb begin
      count_ext  = CMP_W'(count_ff);
      active_cmp = (count_ext > CMP_W'(NUM_PARTITIONS)) ? CMP_W'(NUM_PARTITIONS) : count_ext;
      active     = CNT_W'(active_cmp);
      start      = (CNT_W'(pointer_ff) < active) ? pointer_ff : '0;
   end

   always_comb begin
      req_size_wide  = SZ_XW'(req_payload.size_value);
      req_want       = req_size_wide[SIZE_BITS-1:0];
      load_left_wide = SZ_XW'(req_want);
      req_idx        = IDX_W'(req_payload.part_index);
      load_in_table  = (32'(req_payload.part_index) < NUM_PARTITIONS);
      req_accept     = req_valid && !req_stall;
   end

   // Next fit falls back to the wrapped candidate when nothing at or after
   // the start index fits.
   always_comb begin
      grant     = tail_ctl.cand_found
                  || ((policy_ff == fpfa_pkg::FIT_NEXT) && tail_ctl.wrap_found);
      pick_idx  = tail_ctl.cand_found ? tail_cand_idx : tail_wrap_idx;
      pick_size = tail_ctl.cand_found ? tail_cand_size : tail_wrap_size;
      pick_left = pick_size - want_ff;
      pick_idx_wide  = IDX_XW'(pick_idx);
      pick_left_wide = SZ_XW'(pick_left);
   end

   assign req_stall = (state_ff != fpfa_pkg::ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      pointer_in   = pointer_ff;
      want_in      = want_ff;
      launch_in    = 1'b0;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_en        = 1'b0;
      wr_idx       = req_idx;
      wr_size      = req_want;
      wr_used      = 1'b0;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         fpfa_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_payload.opcode == fpfa_pkg::OP_REQUEST) begin
                  want_in   = req_want;
                  launch_in = 1'b1;
                  state_in  = fpfa_pkg::ST_SCAN;
               end else begin
                  res_in = '0;
                  if (load_in_table) begin
                     wr_en                = 1'b1;
                     res_in.granted       = 1'b1;
                     res_in.granted_index = req_payload.part_index;
                     res_in.leftover_size = load_left_wide[fpfa_pkg::FIELD_SIZE_BITS-1:0];
                  end
                  state_in = fpfa_pkg::ST_RESULT;
               end
            end
         end
         fpfa_pkg::ST_SCAN: begin
            if (tail_ctl.valid) begin
               res_in = '0;
               if (grant) begin
                  wr_en   = 1'b1;
                  wr_idx  = pick_idx;
                  wr_size = pick_left;
                  wr_used = 1'b1;
                  if (policy_ff == fpfa_pkg::FIT_NEXT) begin
                     pointer_in = pick_idx;
                  end
                  res_in.granted       = 1'b1;
                  res_in.granted_index = pick_idx_wide[fpfa_pkg::INDEX_BITS-1:0];
                  res_in.leftover_size = pick_left_wide[fpfa_pkg::FIELD_SIZE_BITS-1:0];
               end
               state_in = fpfa_pkg::ST_RESULT;
            end
         end
         fpfa_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = fpfa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fpfa_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fpfa_pkg::ST_IDLE;
         pointer_ff   <= '0;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pointer_ff   <= pointer_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      want_ff <= want_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= fpfa_pkg::FIT_FIRST;
         count_ff  <= fpfa_pkg::COUNT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            fpfa_pkg::CSR_FIT_POLICY: begin
               policy_ff <= fpfa_pkg::fit_policy_type'(csr_wdata[fpfa_pkg::POLICY_BITS-1:0]);
            end
            fpfa_pkg::CSR_PARTITIONS_IN_USE: begin
               count_ff <= csr_wdata[fpfa_pkg::COUNT_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   fpfa_chain #(
      .NUM_CELLS (NUM_PARTITIONS),
      .IDX_W     (IDX_W),
      .CNT_W     (CNT_W),
      .SIZE_W    (SIZE_BITS)
   ) u_chain (
      .clock          (clock),
      .reset          (reset),
      .wr_en          (wr_en),
      .wr_idx         (wr_idx),
      .wr_size        (wr_size),
      .wr_used        (wr_used),
      .policy         (policy_ff),
      .want           (want_ff),
      .start          (start),
      .active         (active),
      .launch         (launch_ff),
      .tail_ctl       (tail_ctl),
      .tail_cand_idx  (tail_cand_idx),
      .tail_cand_size (tail_cand_size),
      .tail_wrap_idx  (tail_wrap_idx),
      .tail_wrap_size (tail_wrap_size)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> rtl/fpfa_check.sv
// Port-level checker for the fixed partition fit allocator and its bind to
// the top level. Depends on fpfa_pkg.
module fpfa_check (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input fpfa_pkg::req_type req_payload,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input fpfa_pkg::rsp_type rsp_payload
);

   // A result that is held back keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result item changed while stalled");

   // A refused item carries all-zero fields.
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.granted |->
         (rsp_payload.granted_index == '0) && (rsp_payload.leftover_size == '0))
      else $error("refused item has nonzero fields");

   // The block works on one item at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item accepted while one is in work");

   // A request searches the cell row, so its result cannot follow at once.
   a_request_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_payload.opcode == fpfa_pkg::OP_REQUEST)
         |=> !$rose(rsp_valid))
      else $error("result appeared right after a request item");

endmodule

bind fixed_partition_fit_allocator_unit fpfa_check u_fpfa_check (.*);

>>> tb/fixed_partition_fit_allocator_unit_test.sv
// Testbench for fixed_partition_fit_allocator_unit: directed and random items checked
// against a partition table predictor kept in step with every accepted item.
// Depends on fpfa_pkg and the allocator RTL.
`timescale 1ns / 100ps

module fixed_partition_fit_allocator_unit_test;

   localparam int PARTS        = 16;
   localparam int SCAN_LATENCY = PARTS + 3;
   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 200;

   logic                                clock       = 1'b0;
   logic                                reset       = 1'b1;
   logic                                csr_wr_en   = 1'b0;
   logic [fpfa_pkg::CSR_INDEX_BITS-1:0] csr_index   = '0;
   logic [fpfa_pkg::CSR_DATA_BITS-1:0]  csr_wdata   = '0;
   logic                                req_valid   = 1'b0;
   fpfa_pkg::req_type                   req_payload = '0;
   logic                                rsp_stall   = 1'b0;
   logic                                req_stall;
   logic                                rsp_valid;
   fpfa_pkg::rsp_type                   rsp_payload;

   // Predicted partition table, pointer and registers.
   logic [fpfa_pkg::FIELD_SIZE_BITS-1:0] part_size [PARTS];
   bit                                   part_used [PARTS];
   logic [fpfa_pkg::INDEX_BITS-1:0]      next_ptr;
   fpfa_pkg::fit_policy_type             policy_now;
   int                                   count_now;

   fpfa_pkg::rsp_type pending_results [$];
   fpfa_pkg::rsp_type expected_rsp;
   int      fail_count      = 0;
   int      results_checked = 0;
   int      items_sent      = 0;
   int      requests_seen   = 0;
   int      requests_granted = 0;
   int      quiet_cycles    = 0;
   int      hold_left       = 0;
   bit      hold_request    = 1'b0;
   bit      calm            = 1'b0;

   fixed_partition_fit_allocator_unit #(
      .NUM_PARTITIONS(PARTS),
      .SIZE_BITS(fpfa_pkg::FIELD_SIZE_BITS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload)
   );

   always #1 clock = ~clock;

   // Applies one item to the predicted table and returns the result it should give.
   function automatic fpfa_pkg::rsp_type allocate_partition(fpfa_pkg::req_type item);
      fpfa_pkg::rsp_type r;
      int      n;
      int      pick;
      int      start;
      int      idx;
      int      i;
      r = '0;
      if (item.opcode == fpfa_pkg::OP_LOAD) begin
         part_size[item.part_index] = item.size_value;
         part_used[item.part_index] = 1'b0;
         r.granted       = 1'b1;
         r.granted_index = item.part_index;
         r.leftover_size = item.size_value;
         return r;
      end
      requests_seen++;
      n    = (count_now > PARTS) ? PARTS : count_now;
      pick = -1;
      if (policy_now == fpfa_pkg::FIT_NEXT) begin
         // The scan wraps, and a pointer at or past the active count restarts at zero.
         start = (next_ptr < n) ? int'(next_ptr) : 0;
         for (i = 0; i < n && pick < 0; i++) begin
            idx = (start + i) % n;
            if (!part_used[idx] && part_size[idx] >= item.size_value) pick = idx;
         end
      end else begin
         for (i = 0; i < n; i++) begin
            if (part_used[i] || part_size[i] < item.size_value) continue;
            if (pick < 0) begin
               pick = i;
               if (policy_now == fpfa_pkg::FIT_FIRST) break;
            end else if (policy_now == fpfa_pkg::FIT_BEST
                         && part_size[i] < part_size[pick]) begin
               pick = i;
            end else if (policy_now == fpfa_pkg::FIT_WORST
                         && part_size[i] > part_size[pick]) begin
               pick = i;
            end
         end
      end
      if (pick >= 0) begin
         part_size[pick] = part_size[pick] - item.size_value;
         part_used[pick] = 1'b1;
         if (policy_now == fpfa_pkg::FIT_NEXT) next_ptr = pick[fpfa_pkg::INDEX_BITS-1:0];
         r.granted       = 1'b1;
         r.granted_index = pick[fpfa_pkg::INDEX_BITS-1:0];
         r.leftover_size = part_size[pick];
         requests_granted++;
      end
      return r;
   endfunction

   function automatic fpfa_pkg::req_type make_item(fpfa_pkg::opcode_type op,
                                                   logic [fpfa_pkg::INDEX_BITS-1:0] index,
                                                   logic [fpfa_pkg::FIELD_SIZE_BITS-1:0] size);
      fpfa_pkg::req_type item;
      item.opcode     = op;
      item.part_index = index;
      item.size_value = size;
      return item;
   endfunction

   // Requests outnumber loads; request sizes lean toward values that fit exactly.
   function automatic fpfa_pkg::req_type random_item();
      fpfa_pkg::req_type item;
      int      pick;
      item.opcode     = ($urandom_range(0, 9) < 6) ? fpfa_pkg::OP_REQUEST : fpfa_pkg::OP_LOAD;
      item.part_index = fpfa_pkg::INDEX_BITS'($urandom);
      item.size_value = fpfa_pkg::FIELD_SIZE_BITS'($urandom);
      pick = $urandom_range(0, 9);
      if (item.opcode == fpfa_pkg::OP_LOAD) begin
         if (pick == 0) item.size_value = '0;
         else if (pick == 1) item.size_value = '1;
      end else begin
         case (pick)
            0:       item.size_value = '0;
            1:       item.size_value = '1;
            2, 3:    item.size_value = part_size[$urandom_range(0, PARTS - 1)];
            4, 5:    item.size_value = fpfa_pkg::FIELD_SIZE_BITS'($urandom_range(0, 255));
            default: ;
         endcase
      end
      return item;
   endfunction

   task automatic send_item(input fpfa_pkg::req_type item);
      if (!calm && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(allocate_partition(item));
      items_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SCAN_LATENCY) @(posedge clock);
   endtask

   task automatic write_register(input logic [fpfa_pkg::CSR_INDEX_BITS-1:0] index,
                                 input logic [fpfa_pkg::CSR_DATA_BITS-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (index == fpfa_pkg::CSR_FIT_POLICY) begin
         policy_now = fpfa_pkg::fit_policy_type'(value[fpfa_pkg::POLICY_BITS-1:0]);
      end else begin
         count_now = int'(value);
      end
      @(posedge clock);
   endtask

   task automatic set_config(input fpfa_pkg::fit_policy_type pol, input int count);
      logic [fpfa_pkg::CSR_DATA_BITS-fpfa_pkg::POLICY_BITS-1:0] junk;
      junk = (fpfa_pkg::CSR_DATA_BITS-fpfa_pkg::POLICY_BITS)'($urandom);
      wait_idle();
      // Upper bits of the policy write are don't-care and are randomized.
      write_register(fpfa_pkg::CSR_FIT_POLICY, {junk, pol});
      write_register(fpfa_pkg::CSR_PARTITIONS_IN_USE, count[fpfa_pkg::CSR_DATA_BITS-1:0]);
   endtask

   // Every partition is loaded before the first request so no search reads an
   // unwritten size.
   task automatic test_load_table();
      logic [fpfa_pkg::FIELD_SIZE_BITS-1:0] size;
      int i;
      for (i = 0; i < PARTS; i++) begin
         case (i)
            0:       size = 16'h0000;
            1, 9:    size = 16'hFFFF;
            2:       size = 16'h5555;
            3:       size = 16'hAAAA;
            6, 7:    size = 16'h0100;
            default: size = fpfa_pkg::FIELD_SIZE_BITS'($urandom);
         endcase
         send_item(make_item(fpfa_pkg::OP_LOAD, i[fpfa_pkg::INDEX_BITS-1:0], size));
      end
   endtask

   task automatic test_fit_policies();
      // Registers still hold their reset values here: first fit over all partitions.
      send_item(make_item(fpfa_pkg::OP_REQUEST, 4'hF, 16'h0000));
      send_item(make_item(fpfa_pkg::OP_REQUEST, 4'h0, 16'h0100));
      set_config(fpfa_pkg::FIT_BEST, PARTS);
      send_item(make_item(fpfa_pkg::OP_REQUEST, 4'h5, 16'h0100));
      set_config(fpfa_pkg::FIT_WORST, PARTS);
      send_item(make_item(fpfa_pkg::OP_REQUEST, 4'hA, 16'hFFFF));
      set_config(fpfa_pkg::FIT_NEXT, PARTS);
      send_item(make_item(fpfa_pkg::OP_REQUEST, 4'h3, 16'h0001));
      send_item(make_item(fpfa_pkg::OP_REQUEST, 4'hC, 16'h0001));
      send_item(make_item(fpfa_pkg::OP_REQUEST, 4'h0, 16'hFFFF));
   endtask

   task automatic test_count_edges();
      set_config(fpfa_pkg::FIT_NEXT, 0);
      send_item(make_item(fpfa_pkg::OP_REQUEST, 4'h0, 16'h0000));
      set_config(fpfa_pkg::FIT_NEXT, 31);
      send_item(make_item(fpfa_pkg::OP_REQUEST, 4'h0, 16'h0000));
      send_item(make_item(fpfa_pkg::OP_LOAD, 4'hE, 16'hFFFF));
      send_item(make_item(fpfa_pkg::OP_REQUEST, 4'h7, 16'hFFFF));
      // The pointer now sits above the count of four, so next fit restarts at zero.
      set_config(fpfa_pkg::FIT_NEXT, 4);
      send_item(make_item(fpfa_pkg::OP_LOAD, 4'hF, 16'h0005));
      send_item(make_item(fpfa_pkg::OP_LOAD, 4'h0, 16'h0010));
      send_item(make_item(fpfa_pkg::OP_REQUEST, 4'h9, 16'h0001));
   endtask

   task automatic test_receiver_holdoff();
      int i;
      set_config(fpfa_pkg::fit_policy_type'($urandom_range(0, 3)), PARTS);
      calm         = 1'b1;
      hold_request = 1'b1;
      for (i = 0; i < 10; i++) send_item(random_item());
      wait_idle();
      calm = 1'b0;
   endtask

   task automatic test_random_traffic();
      int phase;
      int count;
      int i;
      for (phase = 0; phase < 12; phase++) begin
         case (phase)
            0:       count = PARTS;
            1:       count = 1;
            5:       count = 0;
            7:       count = 31;
            default: count = $urandom_range(1, PARTS);
         endcase
         // Each phase starts only after the sender has paused for all results.
         set_config(fpfa_pkg::fit_policy_type'(phase % 4), count);
         calm = (phase == 2);
         for (i = 0; i < 50; i++) send_item(random_item());
      end
      calm = 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result: granted %0d index %0d leftover %h", $time,
                     rsp_payload.granted, rsp_payload.granted_index, rsp_payload.leftover_size);
            fail_count++;
         end else begin
            expected_rsp = pending_results.pop_front();
            results_checked++;
            if (rsp_payload.granted !== expected_rsp.granted ||
                rsp_payload.granted_index !== expected_rsp.granted_index ||
                rsp_payload.leftover_size !== expected_rsp.leftover_size) begin
               $display({"%0t: mismatch: expected granted %0d index %0d leftover %h,",
                         " got granted %0d index %0d leftover %h"},
                        $time, expected_rsp.granted, expected_rsp.granted_index,
                        expected_rsp.leftover_size, rsp_payload.granted,
                        rsp_payload.granted_index, rsp_payload.leftover_size);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < 10);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < PARTS; i++) begin
         part_size[i] = '0;
         part_used[i] = 1'b0;
      end
      next_ptr   = '0;
      policy_now = fpfa_pkg::FIT_FIRST;
      count_now  = int'(fpfa_pkg::COUNT_RESET);
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_load_table();
      test_fit_policies();
      test_count_edges();
      test_receiver_holdoff();
      test_random_traffic();
      wait_idle();
      fail_count += pending_results.size();
      $display("Sent %0d items, %0d of them requests (%0d granted); checked %0d results.",
               items_sent, requests_seen, requests_granted, results_checked);
      $display("Covered all four fit policies, counts 0 to 31, stalls and a long receiver hold.");
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
